>>> sv/json_balance_validator_macros.svh
// Assertion macros for the checker file of this block.
`ifndef JSON_BALANCE_VALIDATOR_MACROS_SVH
`define JSON_BALANCE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JBV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JBV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/jbv_pkg.sv
`default_nettype none

package jbv_pkg;

	localparam int CHAR_W = 8;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNDERFLOW = 3'd1,
		ERR_UNBALANCE = 3'd2,
		ERR_OPEN_STR  = 3'd3,
		ERR_OVERFLOW  = 3'd4
	} err_kind_t;

	localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_BSLASH   = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_QUOTE    = 8'h22;

endpackage

`default_nettype wire

>>> sv/json_balance_validator.sv
// Brace and bracket balance checker for JSON text. Each input word carries one
// byte, and a word with end_marker set closes the text; only that end word
// produces an output word, giving text_valid and error_kind, after which all
// tracking state returns to zero for the next text. One word is accepted per
// clock while in_ready is high. An accepted word is held in an input register
// and then processed against the depth counters and string/escape flags; an
// end word then loads the result register once the output word is free.
// in_ready drops only while an end word waits in the input register behind an
// output word that has not been taken. Depth counters saturate at MAX_DEPTH.
`default_nettype none

module json_balance_validator #(
	parameter int MAX_DEPTH = 255
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [jbv_pkg::CHAR_W-1:0] char_code,
	input  wire logic                      end_marker,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           text_valid,
	output logic [2:0]                     error_kind
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

	// Input register.
	logic                       valid_s1;
	logic [jbv_pkg::CHAR_W-1:0] char_s1;
	logic                       end_s1;

	// Tracking state.
	logic [DEPTH_W-1:0]  brace_q, brace_d;
	logic [DEPTH_W-1:0]  bracket_q, bracket_d;
	logic                in_str_q, in_str_d;
	logic                esc_q, esc_d;
	jbv_pkg::err_kind_t  err_q, err_d;

	// Result register.
	logic                out_valid_q;
	logic                text_valid_q;
	jbv_pkg::err_kind_t  kind_q;

	logic                advance;
	logic                load_out;
	jbv_pkg::err_kind_t  kind;

	// An end word may leave the input register only when the result slot is free.
	assign advance  = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load_out = advance && end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			end_s1  <= end_marker;
		end
	end

	always_comb begin
		brace_d   = brace_q;
		bracket_d = bracket_q;
		in_str_d  = in_str_q;
		esc_d     = esc_q;
		err_d     = err_q;
		if (advance) begin
			if (end_s1) begin
				brace_d   = '0;
				bracket_d = '0;
				in_str_d  = 1'b0;
				esc_d     = 1'b0;
				err_d     = jbv_pkg::ERR_NONE;
			end else if (err_q == jbv_pkg::ERR_NONE) begin
				if (esc_q) begin
					esc_d = 1'b0;
				end else begin
					case (char_s1)
						jbv_pkg::CH_BSLASH: begin
							esc_d = 1'b1;
						end
						jbv_pkg::CH_QUOTE: begin
							in_str_d = !in_str_q;
						end
						jbv_pkg::CH_LBRACE: begin
							if (!in_str_q) begin
								if (brace_q == DEPTH_MAX) begin
									err_d = jbv_pkg::ERR_OVERFLOW;
								end else begin
									brace_d = brace_q + 1'b1;
								end
							end
						end
						jbv_pkg::CH_RBRACE: begin
							if (!in_str_q) begin
								if (brace_q == '0) begin
									err_d = jbv_pkg::ERR_UNDERFLOW;
								end else begin
									brace_d = brace_q - 1'b1;
								end
							end
						end
						jbv_pkg::CH_LBRACKET: begin
							if (!in_str_q) begin
								if (bracket_q == DEPTH_MAX) begin
									err_d = jbv_pkg::ERR_OVERFLOW;
								end else begin
									bracket_d = bracket_q + 1'b1;
								end
							end
						end
						jbv_pkg::CH_RBRACKET: begin
							if (!in_str_q) begin
								if (bracket_q == '0) begin
									err_d = jbv_pkg::ERR_UNDERFLOW;
								end else begin
									bracket_d = bracket_q - 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// A sticky error wins, then open depth, then an open string.
	always_comb begin
		if (err_q != jbv_pkg::ERR_NONE) begin
			kind = err_q;
		end else if (brace_q != '0 || bracket_q != '0) begin
			kind = jbv_pkg::ERR_UNBALANCE;
		end else if (in_str_q) begin
			kind = jbv_pkg::ERR_OPEN_STR;
		end else begin
			kind = jbv_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brace_q     <= '0;
			bracket_q   <= '0;
			in_str_q    <= 1'b0;
			esc_q       <= 1'b0;
			err_q       <= jbv_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			brace_q   <= brace_d;
			bracket_q <= bracket_d;
			in_str_q  <= in_str_d;
			esc_q     <= esc_d;
			err_q     <= err_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q       <= kind;
			text_valid_q <= (kind == jbv_pkg::ERR_NONE);
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = text_valid_q;
	assign error_kind = kind_q;

endmodule

`default_nettype wire

>>> sv/jbv_checker.sv
`default_nettype none

`include "json_balance_validator_macros.svh"

module jbv_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [jbv_pkg::CHAR_W-1:0] char_code,
	input wire logic                       end_marker,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       text_valid,
	input wire logic [2:0]                 error_kind
);

	logic                   end_acc;
	logic                   ok_agrees;
	logic                   kind_legal;
	logic                   in_stall;
	logic                   out_stall;
	logic [jbv_pkg::CHAR_W:0] in_word;
	logic [3:0]             out_word;

	assign end_acc    = in_valid && in_ready && end_marker;
	assign ok_agrees  = text_valid == (error_kind == jbv_pkg::ERR_NONE);
	assign kind_legal = error_kind <= jbv_pkg::ERR_OVERFLOW;
	assign in_stall   = in_valid && !in_ready;
	assign out_stall  = out_valid && !out_ready;
	assign in_word    = {char_code, end_marker};
	assign out_word   = {text_valid, error_kind};

	// The valid flag must agree with the error code.
	`JBV_ASSERT_IMP(a_valid_matches_kind, clk, arst_n, out_valid, ok_agrees, "text_valid disagrees")

	// Only defined error codes are reported.
	`JBV_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, kind_legal, "error_kind out of range")

	// A fresh result must be traced back to an earlier accepted end word.
	`JBV_ASSERT_IMP(a_result_from_end, clk, arst_n, $rose(out_valid), $past(end_acc, 2), "orphan result")

	// A stalled result word holds.
	`JBV_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_word), "result changed")

	// A waiting input word holds.
	`JBV_ASSERT_NXT(a_in_hold, clk, arst_n, in_stall, in_valid && $stable(in_word), "input changed")

endmodule

bind json_balance_validator jbv_checker u_jbv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.char_code  (char_code),
	.end_marker (end_marker),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.text_valid (text_valid),
	.error_kind (error_kind)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_DEPTH = 255;
	localparam int RANDOM_WORDS = 160;
	localparam int MIN_RANDOM_TEXTS = 10;
	localparam int IDLE_PERCENT = 18;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0] ch;
		bit         last;
		bit         drain_first;
	} text_word_t;

	typedef struct {
		bit                 ok;
		jbv_pkg::err_kind_t kind;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = '0;
	logic       end_marker = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       text_valid;
	logic [2:0] error_kind;

	text_word_t pending[$];
	verdict_t   verdicts[$];
	verdict_t   due;
	bit         drain_next = 1'b0;
	bit         took_word = 1'b0;
	int         words_taken = 0;
	int         mismatch_count = 0;
	int         cycle_count = 0;

	// Shadow of the checker state.
	logic [7:0]         brace_lvl = '0;
	logic [7:0]         bracket_lvl = '0;
	bit                 in_str = 1'b0;
	bit                 esc = 1'b0;
	jbv_pkg::err_kind_t first_err = jbv_pkg::ERR_NONE;

	json_balance_validator #(
		.MAX_DEPTH(MAX_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_marker(end_marker),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_valid(text_valid),
		.error_kind(error_kind)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string note);
		$display("cycle %0d: %s", cycle_count, note);
		mismatch_count++;
	endtask

	task automatic queue_word(input logic [7:0] ch, input bit last);
		text_word_t w;
		w.ch = ch;
		w.last = last;
		w.drain_first = drain_next;
		drain_next = 1'b0;
		pending.push_back(w);
	endtask

	task automatic queue_end();
		queue_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_word(s[i], 1'b0);
		queue_end();
	endtask

	task automatic track_word(input logic [7:0] ch, input bit last);
		verdict_t v;
		if (last) begin
			if (first_err != jbv_pkg::ERR_NONE)
				v.kind = first_err;
			else if (brace_lvl != 0 || bracket_lvl != 0)
				v.kind = jbv_pkg::ERR_UNBALANCE;
			else if (in_str)
				v.kind = jbv_pkg::ERR_OPEN_STR;
			else
				v.kind = jbv_pkg::ERR_NONE;
			v.ok = (v.kind == jbv_pkg::ERR_NONE);
			verdicts.push_back(v);
			brace_lvl = '0;
			bracket_lvl = '0;
			in_str = 1'b0;
			esc = 1'b0;
			first_err = jbv_pkg::ERR_NONE;
		end else if (first_err == jbv_pkg::ERR_NONE) begin
			// An escape swallows the next byte whatever it is, even outside strings.
			if (esc) begin
				esc = 1'b0;
			end else if (ch == jbv_pkg::CH_BSLASH) begin
				esc = 1'b1;
			end else if (ch == jbv_pkg::CH_QUOTE) begin
				in_str = !in_str;
			end else if (!in_str) begin
				case (ch)
					jbv_pkg::CH_LBRACE: begin
						if (brace_lvl >= MAX_DEPTH)
							first_err = jbv_pkg::ERR_OVERFLOW;
						else
							brace_lvl++;
					end
					jbv_pkg::CH_RBRACE: begin
						if (brace_lvl == 0)
							first_err = jbv_pkg::ERR_UNDERFLOW;
						else
							brace_lvl--;
					end
					jbv_pkg::CH_LBRACKET: begin
						if (bracket_lvl >= MAX_DEPTH)
							first_err = jbv_pkg::ERR_OVERFLOW;
						else
							bracket_lvl++;
					end
					jbv_pkg::CH_RBRACKET: begin
						if (bracket_lvl == 0)
							first_err = jbv_pkg::ERR_UNDERFLOW;
						else
							bracket_lvl--;
					end
					default: ;
				endcase
			end
		end
	endtask

	// Mostly well-nested JSON-like texts; about a quarter are damaged on purpose.
	task automatic queue_random_text();
		bit opener_is_bracket[$];
		bit broken;
		bit closer_is_bracket;
		int steps;
		int n;
		broken = ($urandom_range(0, 99) < 25);
		steps = $urandom_range(0, 12);
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					if (opener_is_bracket.size() < 6) begin
						opener_is_bracket.push_back(1'($urandom_range(0, 1)));
						queue_word(opener_is_bracket[$] ? jbv_pkg::CH_LBRACKET
							: jbv_pkg::CH_LBRACE, 1'b0);
					end
				end
				2, 3: begin
					if (opener_is_bracket.size() != 0) begin
						closer_is_bracket = opener_is_bracket.pop_back();
						queue_word(closer_is_bracket ? jbv_pkg::CH_RBRACKET
							: jbv_pkg::CH_RBRACE, 1'b0);
					end else if (broken) begin
						queue_word($urandom_range(0, 1) ? jbv_pkg::CH_RBRACKET
							: jbv_pkg::CH_RBRACE, 1'b0);
					end
				end
				4, 5: begin
					queue_word(jbv_pkg::CH_QUOTE, 1'b0);
					n = $urandom_range(0, 4);
					for (int j = 0; j < n; j++) begin
						case ($urandom_range(0, 4))
							0: begin
								queue_word(jbv_pkg::CH_BSLASH, 1'b0);
								queue_word(jbv_pkg::CH_QUOTE, 1'b0);
							end
							1: begin
								queue_word(jbv_pkg::CH_BSLASH, 1'b0);
								queue_word(jbv_pkg::CH_BSLASH, 1'b0);
							end
							2: queue_word($urandom_range(0, 1) ? jbv_pkg::CH_LBRACE
								: jbv_pkg::CH_RBRACKET, 1'b0);
							default: queue_word(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
						endcase
					end
					if (!broken || $urandom_range(0, 3) != 0)
						queue_word(jbv_pkg::CH_QUOTE, 1'b0);
				end
				6: queue_word(broken ? 8'($urandom_range(0, 255))
					: 8'(8'h30 + $urandom_range(0, 9)), 1'b0);
				7: queue_word($urandom_range(0, 1) ? 8'h2C : 8'h3A, 1'b0);
				8: begin
					queue_word(jbv_pkg::CH_BSLASH, 1'b0);
					queue_word(8'($urandom_range(0, 255)), 1'b0);
				end
				default: queue_word(8'h20, 1'b0);
			endcase
		end
		while (opener_is_bracket.size() != 0) begin
			closer_is_bracket = opener_is_bracket.pop_back();
			if (!broken || $urandom_range(0, 2) != 0)
				queue_word(closer_is_bracket ? jbv_pkg::CH_RBRACKET
					: jbv_pkg::CH_RBRACE, 1'b0);
		end
		if (broken && $urandom_range(0, 3) == 0)
			queue_word(jbv_pkg::CH_BSLASH, 1'b0);
		queue_end();
	endtask

	initial begin
		int first_random;
		int texts;

		queue_text("");
		queue_text("{}");
		queue_text("}");
		queue_text("]");
		queue_text("[");
		queue_text("\"");
		queue_text("{\"");
		queue_text("]{");
		queue_text("\\");
		queue_text("\"\\\"}\"");
		queue_text("\\{");
		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_end();

		// Depth limit on the bracket counter; the close after the overflow must be ignored.
		drain_next = 1'b1;
		for (int k = 0; k <= MAX_DEPTH; k++)
			queue_word(jbv_pkg::CH_LBRACKET, 1'b0);
		queue_word(jbv_pkg::CH_RBRACKET, 1'b0);
		queue_end();

		first_random = pending.size();
		texts = 0;
		while (pending.size() - first_random < RANDOM_WORDS || texts < MIN_RANDOM_TEXTS) begin
			if (texts == 5)
				drain_next = 1'b1;
			queue_random_text();
			texts++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	function automatic bit idle_now();
		// One long calm stretch in the middle of the random texts.
		if (words_taken >= 300 && words_taken < 400)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !took_word) begin
				// Word still waiting for acceptance: hold it.
			end else if (pending.size() != 0
					&& !(pending[0].drain_first && verdicts.size() != 0)
					&& !idle_now()) begin
				in_valid <= 1'b1;
				char_code <= pending[0].ch;
				end_marker <= pending[0].last;
				void'(pending.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
			out_ready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdicts.size() == 0) begin
					report_mismatch("result word with no end word pending");
				end else begin
					due = verdicts.pop_front();
					if (text_valid !== due.ok)
						report_mismatch($sformatf("text_valid %b, want %b", text_valid, due.ok));
					if (error_kind !== due.kind)
						report_mismatch($sformatf("error_kind %0d, want %0d",
							error_kind, due.kind));
				end
			end
			if (in_valid && in_ready) begin
				track_word(char_code, end_marker);
				words_taken++;
			end
			took_word <= in_valid && in_ready;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
